/* rtl/bilinear_flow_warp_with_decay_top_macros.svh */
// Assertion macros shared by the flow warp RTL.
`ifndef BILINEAR_FLOW_WARP_WITH_DECAY_TOP_MACROS_SVH
`define BILINEAR_FLOW_WARP_WITH_DECAY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BFWD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define BFWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BFWD_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFWD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/bfwd_pkg.sv */
// Types, constants and codes of the flow warp block.
`default_nettype none

package bfwd_pkg;

  // frame geometry and sampling grid
  localparam int unsigned FRAME_WIDTH  = 512;
  localparam int unsigned FRAME_HEIGHT = 512;
  localparam int unsigned FRAC_STEPS   = 8;

  localparam int unsigned PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned ADDR_W    = $clog2(PIX_COUNT);
  localparam logic [31:0] SRC_LIMIT = 32'(PIX_COUNT - FRAME_WIDTH - 2);

  // fixed field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned IDX_W     = 18;
  localparam int unsigned FRAC_IN_W = 3;
  localparam int unsigned PIX_W     = 8;

  // decay curve
  localparam int unsigned DECAY_BASE = 3200;
  localparam int unsigned DECAY_KNEE = 192;

  // arithmetic widths
  localparam int unsigned FRAC_W  = $clog2(FRAC_STEPS + 1);
  localparam int unsigned WGT_W   = $clog2(FRAC_STEPS * FRAC_STEPS + 1);
  localparam int unsigned DECAY_W = $clog2(DECAY_BASE + 1);
  localparam int unsigned PROD_W  = PIX_W + WGT_W;
  localparam int unsigned NUM_W   = PROD_W + DECAY_W;
  localparam int unsigned SUM_W   = PIX_W + 2;

  // divide by DEN through a ceiling reciprocal, exact for NUM_W-bit dividends
  localparam int unsigned DEN         = FRAC_STEPS * FRAC_STEPS * DECAY_BASE;
  localparam int unsigned DEN_W       = $clog2(DEN + 1);
  localparam int unsigned RECIP_SHIFT = NUM_W + DEN_W;
  localparam int unsigned RECIP_W     = NUM_W + 2;
  localparam int unsigned MUL_W       = NUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL  =
    ((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // result queue
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [WGT_W-1:0]  wgt_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WARP  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SWAP  = 2'd2
  } func_t;

  // write request to the frame stores
  typedef struct packed {
    logic  en_a;
    logic  en_b;
    addr_t addr;
    pix_t  data;
  } store_wr_t;

  typedef struct packed {
    pix_t pixel;
    logic active;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/bfwd_if.sv */
// Input and result channel interfaces of the flow warp block.
`default_nettype none

interface bfwd_in_if;
  import bfwd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     dest_index;
  logic [IDX_W-1:0]     src_index;
  logic [FRAC_IN_W-1:0] frac_x;
  logic [FRAC_IN_W-1:0] frac_y;
  logic [PIX_W-1:0]     pixel_value;

  modport source (
    output valid, func, dest_index, src_index, frac_x, frac_y, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, func, dest_index, src_index, frac_x, frac_y, pixel_value,
    output ready
  );
endinterface

interface bfwd_out_if;
  import bfwd_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             active_frame;

  modport source (output valid, pixel_out, active_frame, input ready);
  modport sink (input valid, pixel_out, active_frame, output ready);
endinterface

`default_nettype wire

/* rtl/bfwd_ram.sv */
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module bfwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

/* rtl/bfwd_frame_store.sv */
// Two frame stores, each held in two copies so that four pixels read at once.
`default_nettype none

module bfwd_frame_store (
  input  logic                       clk,
  input  bfwd_pkg::store_wr_t        wr,
  input  bfwd_pkg::addr_t [3:0]      rd_addr,
  input  logic                       rd_sel_b,
  output bfwd_pkg::pix_t  [3:0]      corner
);
  import bfwd_pkg::*;

  pix_t [3:0] data_a;
  pix_t [3:0] data_b;

  // copy 0 serves the upper row pair, copy 1 the lower
  bfwd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_COUNT)) u_a0 (
    .clk(clk), .we(wr.en_a), .waddr(wr.addr), .wdata(wr.data),
    .raddr0(rd_addr[0]), .raddr1(rd_addr[1]),
    .rdata0(data_a[0]), .rdata1(data_a[1])
  );
  bfwd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_COUNT)) u_a1 (
    .clk(clk), .we(wr.en_a), .waddr(wr.addr), .wdata(wr.data),
    .raddr0(rd_addr[2]), .raddr1(rd_addr[3]),
    .rdata0(data_a[2]), .rdata1(data_a[3])
  );
  bfwd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_COUNT)) u_b0 (
    .clk(clk), .we(wr.en_b), .waddr(wr.addr), .wdata(wr.data),
    .raddr0(rd_addr[0]), .raddr1(rd_addr[1]),
    .rdata0(data_b[0]), .rdata1(data_b[1])
  );
  bfwd_ram #(.WIDTH(PIX_W), .DEPTH(PIX_COUNT)) u_b1 (
    .clk(clk), .we(wr.en_b), .waddr(wr.addr), .wdata(wr.data),
    .raddr0(rd_addr[2]), .raddr1(rd_addr[3]),
    .rdata0(data_b[2]), .rdata1(data_b[3])
  );

  assign corner = rd_sel_b ? data_b : data_a;

endmodule

`default_nettype wire

/* rtl/bfwd_corner_lane.sv */
// One corner's weight, decay and constant divide, three register stages.
`default_nettype none

module bfwd_corner_lane (
  input  logic           clk,
  input  bfwd_pkg::pix_t corner,
  input  bfwd_pkg::wgt_t weight,
  output bfwd_pkg::pix_t term
);
  import bfwd_pkg::*;

  logic [DECAY_W-1:0] over;
  logic [DECAY_W-1:0] decay;
  logic [PROD_W-1:0]  prod;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   num_m1;
  logic [MUL_W-1:0]   quot_full;

  // stage 1: c*W and the decay factor
  always_ff @(posedge clk) begin
    prod  <= PROD_W'(corner) * PROD_W'(weight);
    decay <= DECAY_W'(DECAY_BASE) - over;
  end

  always_comb begin
    if (32'(corner) > 32'(DECAY_KNEE)) begin
      over = DECAY_W'(corner) - DECAY_W'(DECAY_KNEE);
    end else begin
      over = '0;
    end
  end

  // stage 2: N
  always_ff @(posedge clk) begin
    num <= NUM_W'(prod) * NUM_W'(decay);
  end

  // stage 3: (N-1) / DEN by reciprocal, zero for N == 0
  assign num_m1    = num - NUM_W'(1);
  assign quot_full = MUL_W'(num_m1) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (num == '0) begin
      term <= '0;
    end else begin
      term <= quot_full[RECIP_SHIFT +: PIX_W];
    end
  end

endmodule

`default_nettype wire

/* rtl/bfwd_out_fifo.sv */
// Result queue between the fixed-latency pipeline and the output channel.
`default_nettype none

`include "bilinear_flow_warp_with_decay_top_macros.svh"

module bfwd_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bfwd_pkg::out_item_t push_item,
  bfwd_out_if.source          out_ch
);
  import bfwd_pkg::*;

  out_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop                 = out_ch.valid && out_ch.ready;
  assign out_ch.valid        = (count != '0);
  assign out_ch.pixel_out    = mem[rd_ptr].pixel;
  assign out_ch.active_frame = mem[rd_ptr].active;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // credits upstream must keep a slot free for every item in flight
  `BFWD_ASSERT_IMP(a_fifo_no_overflow, clk, rst, push, count != CNT_W'(FIFO_DEPTH))

endmodule

`default_nettype wire

/* rtl/bilinear_flow_warp_with_decay_top.sv */
// Top level of the feedback flow warp with bilinear sampling and decay.
`default_nettype none

`include "bilinear_flow_warp_with_decay_top_macros.svh"

// Feedback warp over two 8-bit frame stores. Takes one item per cycle,
// save for the stalls below: warp (bilinear 2x2 sample with brightness
// decay, written to the destination frame), overlay write, or frame swap;
// each item gives exactly one result, in order. A result passes the
// registered RAM read at the accepting edge, three lane stages and one
// sum/write-back stage before it turns valid in the queue. Each frame
// store is kept in two identical copies with two read ports apiece, so
// the four neighbours of a warp come out in one read. After a swap, input
// stalls until writes still aimed at the new source frame have landed.
// Results queue in an 8-deep FIFO; input is held off only when all 8
// slots are spoken for. After reset the block sweeps both frames to zero,
// one pixel per cycle, and takes no item until all FRAME_WIDTH*FRAME_HEIGHT
// pixels (262144 at 512x512) are cleared.

module bilinear_flow_warp_with_decay_top (
  input  logic       clk,
  input  logic       rst,
  bfwd_in_if.sink    in_ch,
  bfwd_out_if.source out_ch
);
  import bfwd_pkg::*;

  // per-stage item info; weights only live in stage 1
  typedef struct packed {
    logic  wr;       // write destination at write-back
    logic  sel;      // dest_select at accept: 1 reads b, writes a
    logic  is_warp;
    addr_t addr;
    pix_t  value;    // echoed pixel, or zero
    logic  active;
  } stage_t;

  // ---- control state ----
  logic             clearing;
  addr_t            clear_addr;
  logic             dest_select;
  logic             dest_select_next;
  logic [3:0]       stage_valid;
  stage_t           info [4];
  wgt_t   [3:0]     s1_wgt;
  logic [CNT_W-1:0] outstanding;

  // ---- accept-side decode ----
  func_t        in_func;
  logic         accept;
  logic         pop;
  logic         hazard;
  logic [31:0]  src32;
  logic [31:0]  src_sat;
  logic [31:0]  src_p1;
  logic [31:0]  src_pw;
  logic [31:0]  src_pw1;
  logic [31:0]  dest32;
  logic         dest_ok;
  frac_t        fx;
  frac_t        fy;
  frac_t        wx0;
  frac_t        wy0;
  wgt_t [3:0]   wgt_new;
  stage_t       info_new;
  addr_t [3:0]  rd_addr;

  // ---- datapath ----
  pix_t [3:0]   corner;
  pix_t [3:0]   term;
  logic [SUM_W-1:0] sum;
  pix_t         pix_wb;
  store_wr_t    store_wr;
  out_item_t    push_item;

  assign in_func = func_t'(in_ch.func);
  assign accept  = in_ch.valid && in_ch.ready;
  assign pop     = out_ch.valid && out_ch.ready;

  // A write still in flight toward the store that is now the source would
  // be missed by a read issued now.
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (stage_valid[k] && info[k].wr && (info[k].sel != dest_select)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_ch.ready = !clearing && !hazard && (outstanding < CNT_W'(FIFO_DEPTH));

  // source neighbourhood addresses, saturated so all four stay in the frame
  assign src32   = 32'(in_ch.src_index);
  assign src_sat = (src32 > SRC_LIMIT) ? SRC_LIMIT : src32;
  assign src_p1  = src_sat + 32'd1;
  assign src_pw  = src_sat + 32'(FRAME_WIDTH);
  assign src_pw1 = src_sat + 32'(FRAME_WIDTH + 1);

  assign rd_addr[0] = src_sat[ADDR_W-1:0];
  assign rd_addr[1] = src_p1[ADDR_W-1:0];
  assign rd_addr[2] = src_pw[ADDR_W-1:0];
  assign rd_addr[3] = src_pw1[ADDR_W-1:0];

  assign dest32  = 32'(in_ch.dest_index);
  assign dest_ok = dest32 < 32'(PIX_COUNT);

  // bilinear weights in steps of 1/FRAC_STEPS, fractions clamped to S-1
  always_comb begin
    if (32'(in_ch.frac_x) > 32'(FRAC_STEPS - 1)) begin
      fx = frac_t'(FRAC_STEPS - 1);
    end else begin
      fx = frac_t'(in_ch.frac_x);
    end
    if (32'(in_ch.frac_y) > 32'(FRAC_STEPS - 1)) begin
      fy = frac_t'(FRAC_STEPS - 1);
    end else begin
      fy = frac_t'(in_ch.frac_y);
    end
  end

  assign wx0 = frac_t'(FRAC_STEPS) - fx;
  assign wy0 = frac_t'(FRAC_STEPS) - fy;

  // corner order: top-left, top-right, bottom-left, bottom-right
  assign wgt_new[0] = wgt_t'(wx0) * wgt_t'(wy0);
  assign wgt_new[1] = wgt_t'(fx)  * wgt_t'(wy0);
  assign wgt_new[2] = wgt_t'(wx0) * wgt_t'(fy);
  assign wgt_new[3] = wgt_t'(fx)  * wgt_t'(fy);

  always_comb begin
    dest_select_next = dest_select;
    info_new.wr      = 1'b0;
    info_new.sel     = dest_select;
    info_new.is_warp = 1'b0;
    info_new.addr    = dest32[ADDR_W-1:0];
    info_new.value   = '0;
    info_new.active  = dest_select;
    case (in_func)
      FUNC_WARP: begin
        info_new.wr      = dest_ok;
        info_new.is_warp = 1'b1;
      end
      FUNC_WRITE: begin
        info_new.wr    = dest_ok;
        info_new.value = in_ch.pixel_value;
      end
      FUNC_SWAP: begin
        dest_select_next = ~dest_select;
        info_new.active  = ~dest_select;
      end
      default: begin
        // unused code: no state change, zero result
      end
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing    <= 1'b1;
      clear_addr  <= '0;
      dest_select <= 1'b0;
      stage_valid <= '0;
      outstanding <= '0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + ADDR_W'(1);
        if (clear_addr == ADDR_W'(PIX_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        dest_select <= dest_select_next;
      end
      stage_valid <= {stage_valid[2:0], accept};
      case ({accept, pop})
        2'b10:   outstanding <= outstanding + CNT_W'(1);
        2'b01:   outstanding <= outstanding - CNT_W'(1);
        default: outstanding <= outstanding;
      endcase
    end
  end

  // ---- stage payload, no reset ----
  always_ff @(posedge clk) begin
    info[0] <= info_new;
    s1_wgt  <= wgt_new;
    for (int k = 1; k < 4; k++) begin
      info[k] <= info[k-1];
    end
  end

  // ---- frame stores: read at accept, data in stage 1 ----
  bfwd_frame_store u_store (
    .clk      (clk),
    .wr       (store_wr),
    .rd_addr  (rd_addr),
    .rd_sel_b (info[0].sel),
    .corner   (corner)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    bfwd_corner_lane u_lane (
      .clk    (clk),
      .corner (corner[g]),
      .weight (s1_wgt[g]),
      .term   (term[g])
    );
  end

  // ---- stage 4: sum, write back, queue the result ----
  assign sum = SUM_W'(term[0]) + SUM_W'(term[1]) + SUM_W'(term[2]) + SUM_W'(term[3]);

  always_comb begin
    if (!info[3].is_warp) begin
      pix_wb = info[3].value;
    end else if (sum > SUM_W'(255)) begin
      pix_wb = '1;
    end else begin
      pix_wb = sum[PIX_W-1:0];
    end
  end

  always_comb begin
    if (clearing) begin
      store_wr.en_a = 1'b1;
      store_wr.en_b = 1'b1;
      store_wr.addr = clear_addr;
      store_wr.data = '0;
    end else begin
      store_wr.en_a = stage_valid[3] && info[3].wr && info[3].sel;
      store_wr.en_b = stage_valid[3] && info[3].wr && !info[3].sel;
      store_wr.addr = info[3].addr;
      store_wr.data = pix_wb;
    end
  end

  assign push_item.pixel  = pix_wb;
  assign push_item.active = info[3].active;

  bfwd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (stage_valid[3]),
    .push_item (push_item),
    .out_ch    (out_ch)
  );

  // clear sweep owns the write ports: nothing may be in the pipe meanwhile
  `BFWD_ASSERT_IMP(a_idle_while_clearing, clk, rst, clearing, stage_valid == '0)
  // a swap flips the destination on the next cycle
  `BFWD_ASSERT_NEXT(a_swap_flips, clk, rst, accept && (in_func == FUNC_SWAP), dest_select != $past(dest_select))
  // credit count never exceeds the queue depth
  `BFWD_ASSERT_IMP(a_credit_bound, clk, rst, 1'b1, outstanding <= CNT_W'(FIFO_DEPTH))

endmodule

`default_nettype wire
